>>> src/pbtp_pkg.sv
`timescale 1ns / 1ps

package pbtp_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;

    localparam int FIELD_W   = 32;
    localparam int HEADING_W = 18;
    localparam int ACC_W     = 32;
    localparam int DIFF_W    = COORD_WIDTH + 1;
    localparam int VEC_W     = COORD_WIDTH + 3;
    localparam int HEAD_W    = ANGLE_BITS + 2;
    localparam int NUM_STAGES = CORDIC_STAGES + 3;

    localparam logic [ANGLE_BITS-1:0] QUARTER      = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] HALF         = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS-1:0] THREE_QUARTER = QUARTER | HALF;
    localparam logic [ACC_W-1:0]      ACC_HALF_TURN = ACC_W'(1) << (ACC_W - 1);
    localparam logic [ACC_W-1:0]      ROUND_BIAS    = ACC_W'(1) << (ACC_W - 1 - ANGLE_BITS);

    localparam logic signed [HEAD_W-1:0] H_FULL = HEAD_W'(1) << ANGLE_BITS;
    localparam logic signed [HEAD_W-1:0] H_HALF = HEAD_W'(1) << (ANGLE_BITS - 1);

    localparam logic REG_ANGLE_MODE = 1'b0;
    localparam logic REG_ZERO_BAND  = 1'b1;

    localparam logic [1:0] MODE_BEARING    = 2'd0;
    localparam logic [1:0] MODE_YAW        = 2'd1;
    localparam logic [1:0] MODE_YAW_SIGNED = 2'd2;

    // atan(2^-i), full turn = 2^32
    function automatic logic [ACC_W-1:0] atan_turn(input int idx);
        logic [ACC_W-1:0] r;
        case (idx)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051D;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2E;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2F9;
            15: r = 32'h0000517C;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A2F;
            19: r = 32'h00000517;
            20: r = 32'h0000028B;
            21: r = 32'h00000145;
            22: r = 32'h000000A2;
            23: r = 32'h00000051;
            default: r = '0;
        endcase
        return r;
    endfunction

    // low COORD_WIDTH bits of a field, zero above the field
    function automatic logic signed [COORD_WIDTH-1:0] coord_of(input logic [FIELD_W-1:0] v);
        logic signed [COORD_WIDTH-1:0] r;
        for (int i = 0; i < COORD_WIDTH; i++) begin
            r[i] = v[i % FIELD_W] & (i < FIELD_W);
        end
        return r;
    endfunction

endpackage

>>> src/planar_bearing_from_two_points.sv
`timescale 1ns / 1ps

// Direction from a start point to a target point as a binary angle, one word per
// cycle while the output is not stalled. Each word passes through these stages
// from s_ to m_: one forms the differences, one handles the zero band and folds
// the vector into the right half plane, one per unrolled CORDIC stage, and one
// rounds and applies angle_mode. Every stage holds its word when the stage after
// it cannot take it, so bubbles close up while m_tready is low and nothing is dropped.
// Registers: 0x0 angle_mode, 0x4 zero_band; write them only while the block is empty.
module planar_bearing_from_two_points
    import pbtp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // from_x, from_y, to_x, to_y

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata   // heading, zero padding
);

    logic [1:0]  angle_mode_reg;
    logic [15:0] zero_band_reg;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES:0]   rdy;

    logic signed [DIFF_W-1:0] dx_reg, dy_reg;

    logic signed [VEC_W-1:0] x_reg [0:CORDIC_STAGES];
    logic signed [VEC_W-1:0] y_reg [0:CORDIC_STAGES];
    logic [ACC_W-1:0]        acc_reg [0:CORDIC_STAGES];
    logic                    sp_reg [0:CORDIC_STAGES];
    logic [ANGLE_BITS-1:0]   spb_reg [0:CORDIC_STAGES];

    logic signed [HEAD_W-1:0] h_reg, h_next;

    // config port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_mode_reg <= MODE_BEARING;
            zero_band_reg  <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_ANGLE_MODE: angle_mode_reg <= pwdata[1:0];
                REG_ZERO_BAND:  zero_band_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ANGLE_MODE: prdata = {30'd0, angle_mode_reg};
            REG_ZERO_BAND:  prdata = {16'd0, zero_band_reg};
            default:        prdata = '0;
        endcase
    end

    // stage handshake
    always_comb begin
        rdy[NUM_STAGES] = m_tready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tdata  = {6'd0, HEADING_W'(h_reg)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= (k == 0) ? s_tvalid : vld_reg[k > 0 ? k - 1 : 0];
                end
            end
        end
    end

    // differences
    always_ff @(posedge aclk) begin
        if (s_tvalid && rdy[0]) begin
            dx_reg <= DIFF_W'(coord_of(s_tdata[95:64])) - DIFF_W'(coord_of(s_tdata[31:0]));
            dy_reg <= DIFF_W'(coord_of(s_tdata[127:96])) - DIFF_W'(coord_of(s_tdata[63:32]));
        end
    end

    // zero band and half-plane fold
    logic [DIFF_W-1:0] mag_dx, mag_dy;
    logic              in_band_dx, in_band_dy;

    assign mag_dx = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
    assign mag_dy = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);
    assign in_band_dx = mag_dx <= DIFF_W'(zero_band_reg);
    assign in_band_dy = mag_dy <= DIFF_W'(zero_band_reg);

    always_ff @(posedge aclk) begin
        if (vld_reg[0] && rdy[1]) begin
            sp_reg[0] <= in_band_dx || in_band_dy;
            if (in_band_dy) begin
                spb_reg[0] <= (dx_reg > 0) ? QUARTER : THREE_QUARTER;
            end else begin
                spb_reg[0] <= (dy_reg > 0) ? '0 : HALF;
            end
            if (dy_reg < 0) begin
                x_reg[0]   <= -VEC_W'(dy_reg);
                y_reg[0]   <= -VEC_W'(dx_reg);
                acc_reg[0] <= ACC_HALF_TURN;
            end else begin
                x_reg[0]   <= VEC_W'(dy_reg);
                y_reg[0]   <= VEC_W'(dx_reg);
                acc_reg[0] <= '0;
            end
        end
    end

    // vectoring stages
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        always_ff @(posedge aclk) begin
            if (vld_reg[i+1] && rdy[i+2]) begin
                sp_reg[i+1]  <= sp_reg[i];
                spb_reg[i+1] <= spb_reg[i];
                if (y_reg[i] > 0) begin
                    x_reg[i+1]   <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1]   <= y_reg[i] - (x_reg[i] >>> i);
                    acc_reg[i+1] <= acc_reg[i] + atan_turn(i);
                end else begin
                    x_reg[i+1]   <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1]   <= y_reg[i] + (x_reg[i] >>> i);
                    acc_reg[i+1] <= acc_reg[i] - atan_turn(i);
                end
            end
        end
    end

    // rounding and angle mode
    logic [ACC_W-1:0]      rounded;
    logic [ANGLE_BITS-1:0] bearing, shifted;
    logic signed [HEAD_W-1:0] yaw;

    assign rounded = acc_reg[CORDIC_STAGES] + ROUND_BIAS;
    assign bearing = sp_reg[CORDIC_STAGES] ? spb_reg[CORDIC_STAGES]
                                           : rounded[ACC_W-1 -: ANGLE_BITS];
    assign shifted = bearing - QUARTER;
    assign yaw     = H_FULL - $signed(HEAD_W'(shifted));

    always_comb begin
        case (angle_mode_reg)
            MODE_YAW:        h_next = yaw;
            MODE_YAW_SIGNED: h_next = (yaw > H_HALF) ? yaw - H_FULL : yaw;
            default:         h_next = $signed(HEAD_W'(bearing));
        endcase
    end

    always_ff @(posedge aclk) begin
        if (vld_reg[NUM_STAGES-2] && rdy[NUM_STAGES-1]) begin
            h_reg <= h_next;
        end
    end

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted word missing from first stage");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[1] && !rdy[2] |=> vld_reg[1] && $stable(x_reg[0]) && $stable(acc_reg[0]))
        else $error("stalled stage lost its word");

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (h_reg >= -H_HALF) && (h_reg <= H_FULL))
        else $error("heading out of range");

endmodule

>>> verif/planar_bearing_from_two_points_tb.sv
`timescale 1ns / 1ps

module planar_bearing_from_two_points_tb;
    import pbtp_pkg::*;

    localparam logic [1:0] MODE_SPARE   = 2'd3;
    localparam int         DRAIN_CYCLES = NUM_STAGES + 8;
    localparam int         STEP_COUNT   = 24;

    localparam bit [ACC_W-1:0] ATAN_STEP [STEP_COUNT] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    logic         aclk;
    logic         aresetn;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // from_x, from_y, to_x, to_y
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;   // heading, zero padding

    logic [HEADING_W-1:0] expected_headings [$];
    logic [1:0]           cur_mode;
    logic [15:0]          cur_band;
    bit                   src_gaps;
    bit                   sink_gaps;
    int                   hold_cycles;
    int                   fail_count;

    planar_bearing_from_two_points dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [HEADING_W-1:0] predict_heading(
        input logic signed [31:0] fx, fy, tx, ty);
        longint           dx, dy, x, y, nx, full, half, quarter, b, a, h;
        logic [ACC_W-1:0] acc;
        full    = longint'(1) << ANGLE_BITS;
        half    = full / 2;
        quarter = full / 4;
        dx = longint'(tx) - longint'(fx);
        dy = longint'(ty) - longint'(fy);
        if ((dy < 0 ? -dy : dy) <= longint'(cur_band)) begin
            b = dx > 0 ? quarter : 3 * quarter;
        end else if ((dx < 0 ? -dx : dx) <= longint'(cur_band)) begin
            b = dy > 0 ? 0 : half;
        end else begin
            x   = dy;
            y   = dx;
            acc = '0;
            if (x < 0) begin
                x   = -x;
                y   = -y;
                acc = ACC_HALF_TURN;
            end
            for (int i = 0; i < CORDIC_STAGES && i < STEP_COUNT; i++) begin
                if (y > 0) begin
                    nx  = x + (y >>> i);
                    y   = y - (x >>> i);
                    acc = acc + ATAN_STEP[i];
                end else begin
                    nx  = x - (y >>> i);
                    y   = y + (x >>> i);
                    acc = acc - ATAN_STEP[i];
                end
                x = nx;
            end
            b = (({32'b0, acc} + (longint'(1) << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS))
                & (full - 1);
        end
        if (cur_mode == MODE_YAW || cur_mode == MODE_YAW_SIGNED) begin
            a = b - quarter;
            if (a < 0) begin
                a = a + full;
            end
            h = full - a;
            if (cur_mode == MODE_YAW_SIGNED && h > half) begin
                h = h - full;
            end
        end else begin
            h = b;
        end
        return h[HEADING_W-1:0];
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        logic [HEADING_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_headings.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual heading %h",
                         $time, m_tdata[HEADING_W-1:0]);
                fail_count++;
            end else begin
                want = expected_headings.pop_front();
                if (m_tdata[HEADING_W-1:0] !== want) begin
                    $display("%0t: heading mismatch, expected %h, actual %h",
                             $time, want, m_tdata[HEADING_W-1:0]);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_pair(input logic [31:0] fx, fy, tx, ty);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ty, tx, fy, fx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_headings.push_back(predict_heading(fx, fy, tx, ty));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_headings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ANGLE_MODE) begin
            cur_mode = value[1:0];
        end else begin
            cur_band = value[15:0];
        end
        @(posedge aclk);
    endtask

    task automatic configure(input logic [31:0] mode_word, input logic [31:0] band_word);
        wait_idle();
        write_reg(REG_ANGLE_MODE, mode_word);
        write_reg(REG_ZERO_BAND, band_word);
    endtask

    task automatic send_random_pair();
        logic [31:0] fx, fy, tx, ty;
        int          span;
        fx   = $urandom;
        fy   = $urandom;
        tx   = $urandom;
        ty   = $urandom;
        span = int'(cur_band) + 3;
        case ($urandom_range(0, 5))
            1: tx = fx + $urandom_range(0, 2 * span) - span;
            2: ty = fy + $urandom_range(0, 2 * span) - span;
            3: begin
                tx = fx + $urandom_range(0, 2 * span) - span;
                ty = fy + $urandom_range(0, 2 * span) - span;
            end
            4: begin
                tx = fx + $urandom_range(0, 131071) - 65536;
                ty = fy + $urandom_range(0, 131071) - 65536;
            end
            5: begin
                tx = fx + $urandom_range(0, 15) - 8;
                ty = fy + $urandom_range(0, 15) - 8;
            end
            default: ;
        endcase
        send_pair(fx, fy, tx, ty);
    endtask

    task automatic check_axes_and_extremes();
        configure({30'b0, MODE_BEARING}, 32'd0);
        send_pair(32'd0, 32'd0, 32'd0, 32'd0);
        send_pair(32'd0, 32'd0, 32'd1, 32'd0);
        send_pair(32'd0, 32'd0, 32'd0, 32'd1);
        send_pair(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_pair(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_pair(32'd5, 32'hFFFF_FFF9, 32'hFFFB_6C20, 32'h0001_E240);
    endtask

    task automatic check_yaw_modes();
        // two axis directions and an oblique direction in yaw, signed yaw and the spare mode, which gives the bearing
        configure({30'b0, MODE_YAW}, 32'd0);
        send_pair(32'd0, 32'd0, 32'd1, 32'd0);
        send_pair(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_pair(32'd0, 32'd0, 32'hFFFF_FFFD, 32'hFFFF_FFFC);
        configure({30'b0, MODE_YAW_SIGNED}, 32'd0);
        send_pair(32'd0, 32'd0, 32'd1, 32'd0);
        send_pair(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_pair(32'd0, 32'd0, 32'hFFFF_FFFD, 32'hFFFF_FFFC);
        configure({30'b0, MODE_SPARE}, 32'd0);
        send_pair(32'd0, 32'd0, 32'd1, 32'd0);
        send_pair(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_pair(32'd0, 32'd0, 32'd3, 32'hFFFF_FFFC);
    endtask

    task automatic check_zero_band();
        configure({30'b0, MODE_BEARING}, 32'd65535);
        send_pair(32'd0, 32'd0, 32'd65535, 32'd70000);
        send_pair(32'd0, 32'd0, 32'd70000, 32'hFFFF_0001);
        send_pair(32'd0, 32'd0, 32'hFFFF_0000, 32'hFFFF_0000);
        send_pair(32'd0, 32'd0, 32'd65535, 32'hFFFF_0001);
        // upper bits of the register word are dropped
        configure({30'b0, MODE_BEARING}, 32'hFFFF_0001);
        send_pair(32'd0, 32'd0, 32'd2, 32'd1);
        send_pair(32'd0, 32'd0, 32'd1, 32'hFFFF_FFFE);
    endtask

    task automatic check_output_stall();
        src_gaps    = 1'b0;
        hold_cycles = 400;
        repeat (80) send_random_pair();
        src_gaps = 1'b1;
    endtask

    task automatic check_random_pairs();
        logic [31:0] band_word;
        for (int p = 0; p < 10; p++) begin
            case (p % 5)
                0: band_word = 32'd0;
                1: band_word = 32'd65535;
                2: band_word = {16'b0, 16'($urandom)};
                3: band_word = $urandom_range(0, 255);
                default: band_word = $urandom;
            endcase
            configure({30'($urandom), 2'(p % 4)}, band_word);
            if (p >= 8) begin
                src_gaps  = 1'b0;
                sink_gaps = 1'b0;
            end
            repeat (160) send_random_pair();
        end
    endtask

    initial begin
        aresetn     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cur_mode    = MODE_BEARING;
        cur_band    = '0;
        src_gaps    = 1'b1;
        sink_gaps   = 1'b1;
        hold_cycles = 0;
        fail_count  = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        check_axes_and_extremes();
        check_yaw_modes();
        check_zero_band();
        check_output_stall();
        check_random_pairs();

        wait_idle();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/pbtp_pkg.sv
src/planar_bearing_from_two_points.sv
verif/planar_bearing_from_two_points_tb.sv
